### src/sorted_insertion_list_defines.svh
// ============================================================================
// Sorted insertion list assertion macros
// Shared assertion wrappers; they expand to nothing under synthesis.
// ============================================================================
`ifndef SORTED_INSERTION_LIST_DEFINES_SVH
`define SORTED_INSERTION_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define SIL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted_insertion_list: check failed");
`define SIL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sorted_insertion_list: check failed");
`else
`define SIL_ASSERT(lbl, prop)
`define SIL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### src/sil_pkg.sv
// ============================================================================
// Sorted insertion list package
// Field widths, action and status codes, and the stored entry type.
// ============================================================================
package sil_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [TAG_W-1:0]        tag;
    logic signed [KEY_W-1:0] key;
  } entry_t;

endpackage

### src/sil_req_if.sv
// ============================================================================
// Sorted insertion list request channel
// Valid/ready channel carrying one action transaction.
// ============================================================================
interface sil_req_if;
  logic                              valid;
  logic                              ready;
  logic [sil_pkg::ACTION_W-1:0]      action;
  logic [sil_pkg::KIND_W-1:0]        kind;
  logic [sil_pkg::TAG_W-1:0]         tag_index;
  logic signed [sil_pkg::KEY_W-1:0]  sort_key;
  logic [sil_pkg::POS_W-1:0]         read_pos;

  modport source (output valid, action, kind, tag_index, sort_key, read_pos,
                  input ready);
  modport sink (input valid, action, kind, tag_index, sort_key, read_pos,
                output ready);
endinterface

### src/sil_rsp_if.sv
// ============================================================================
// Sorted insertion list result channel
// Valid/ready channel carrying one result transaction.
// ============================================================================
interface sil_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [sil_pkg::STATUS_W-1:0]      status;
  logic [sil_pkg::COUNT_W-1:0]       entry_count;
  logic [sil_pkg::KIND_W-1:0]        out_kind;
  logic [sil_pkg::TAG_W-1:0]         out_tag;
  logic signed [sil_pkg::KEY_W-1:0]  out_key;

  modport source (output valid, status, entry_count, out_kind, out_tag, out_key,
                  input ready);
  modport sink (input valid, status, entry_count, out_kind, out_tag, out_key,
                output ready);
endinterface

### src/sorted_insertion_list.sv
// ============================================================================
// Sorted insertion list
// Bounded list of tagged entries held in ascending signed-key order.
// ============================================================================
// Usage:
//   req carries one action transaction: clear, insert (kind, tag_index,
//   sort_key) or read (read_pos). rsp returns exactly one result per request:
//   status, entry count after the action, and the read entry or zeros.
//   The list sits in a single-port-write, registered-read memory. An insert
//   walks down from the top entry: each step reads one entry and either
//   moves it up one place or writes the new entry; the new entry goes to
//   position zero once every stored entry has moved up. A read waits for
//   the registered memory output; clear and rejected actions go straight
//   to the result.
//   One request is in progress at a time; req.ready is high only when idle.
//   The result sits in an output register; while rsp is stalled the finished
//   result waits and no new request is taken.
//   Reset empties the list at once (count to zero, no memory sweep) and
//   drops any pending result. Entry contents are not cleared.
// ============================================================================
`include "sorted_insertion_list_defines.svh"

module sorted_insertion_list #(
  parameter int unsigned CAPACITY = sil_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sil_req_if.sink   req,
  sil_rsp_if.source rsp
);
  import sil_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned EXT_W = CNT_W + POS_W + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FETCH  = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_next;
  logic [CNT_W-1:0]  idx_m1;

  entry_t            mem [CAPACITY];
  entry_t            mem_rd;
  entry_t            mem_wd;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [IDX_W-1:0]  mem_ra;

  entry_t            new_entry;
  logic              load_new;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;
  entry_t            res_entry;
  entry_t            res_entry_next;

  logic [EXT_W-1:0]  pos_ext;
  logic [EXT_W-1:0]  cnt_ext;
  logic              full;
  logic              range_bad;
  logic              move_up;
  logic              accept;
  logic              out_load;

  logic              out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  entry_t            out_entry;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign pos_ext   = EXT_W'(req.read_pos);
  assign cnt_ext   = EXT_W'(count);
  assign full      = (count >= CNT_W'(CAPACITY));
  assign range_bad = (pos_ext >= cnt_ext);
  assign idx_m1    = idx - 1'b1;
  assign move_up   = ($signed(mem_rd.key) > $signed(new_entry.key));
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    mem_ra = '0;
    case (state)
      S_IDLE:  mem_ra = pos_ext[IDX_W-1:0];
      S_FETCH: mem_ra = idx_m1[IDX_W-1:0];
      default: mem_ra = '0;
    endcase
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    load_new        = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = idx[IDX_W-1:0];
    mem_wd          = new_entry;
    case (state)
      S_IDLE: begin
        if (accept) begin
          load_new        = 1'b1;
          res_status_next = ST_OK;
          res_entry_next  = '0;
          idx_next        = count;
          state_next      = S_DONE;
          case (req.action)
            ACT_CLEAR: begin
              count_next = '0;
            end
            ACT_INSERT: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                state_next = S_FETCH;
              end
            end
            ACT_READ: begin
              if (range_bad) begin
                res_status_next = ST_RANGE;
              end else begin
                state_next = S_RDWAIT;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (idx == '0) begin
          mem_we     = 1'b1;
          mem_wd     = new_entry;
          count_next = count + 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        if (move_up) begin
          mem_wd     = mem_rd;
          idx_next   = idx_m1;
          state_next = S_FETCH;
        end else begin
          mem_wd     = new_entry;
          count_next = count + 1'b1;
          state_next = S_DONE;
        end
      end
      S_RDWAIT: begin
        res_entry_next = mem_rd;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    if (load_new) begin
      new_entry.kind <= req.kind;
      new_entry.tag  <= req.tag_index;
      new_entry.key  <= req.sort_key;
    end
    if (out_load) begin
      out_status <= res_status;
      out_count  <= cnt_ext[COUNT_W-1:0];
      out_entry  <= res_entry;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;
  assign rsp.out_kind    = out_entry.kind;
  assign rsp.out_tag     = out_entry.tag;
  assign rsp.out_key     = out_entry.key;

  `SIL_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY))
  `SIL_ASSERT(a_full_flag, (state == S_DONE && res_status == ST_FULL) |-> full)
  `SIL_ASSERT(a_insert_grows, (state == S_SHIFT && !move_up) |=> count == $past(count) + 1'b1)
  `SIL_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid && count == '0))

endmodule
